@@ sv/sha256_pkg.sv @@
// Shared types and constants of the SHA-256 message hasher.
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;   // element 0 is a (or H0)

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic  push;       // shift a packed message word into the schedule window
    word_t push_word;
    logic  start;      // load working words from the hash state
    logic  run;        // perform one round
  } core_ctrl_t;

  // Status from the round unit back to the sequencer.
  typedef struct packed {
    logic last_round;  // round 63 is being performed this cycle
  } core_stat_t;

  localparam int unsigned ROUNDS = 64;

  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

@@ sv/sha256_core.sv @@
// SHA-256 round unit: schedule window, working words and one round per cycle while run is set.
`default_nettype none

module sha256_core (
  input  wire                     clk,
  input  wire                     rst,
  input  sha256_pkg::core_ctrl_t  ctrl,
  input  sha256_pkg::hash_t       hash_in,
  output sha256_pkg::hash_t       working,
  output sha256_pkg::core_stat_t  stat
);

  function automatic sha256_pkg::word_t rotr(input sha256_pkg::word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Schedule window: window[i] holds W[t+i] during round t.
  sha256_pkg::word_t window [16];
  sha256_pkg::hash_t v;
  logic [5:0]        rnd;

  sha256_pkg::word_t w_new, ss0, ss1, bs0, bs1, ch, maj, t1, t2;

  always_comb begin
    ss0   = rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3);
    ss1   = rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10);
    w_new = window[0] + ss0 + window[9] + ss1;
    bs1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    bs0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + bs1 + ch + sha256_pkg::ROUND_K[rnd] + window[0];
    t2    = bs0 + maj;
  end

  // Advance the window on a loaded word or on every round.
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.run) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i + 1];
      end
      window[15] <= ctrl.push ? ctrl.push_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      v <= hash_in;
    end else if (ctrl.run) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (ctrl.run) begin
      rnd <= rnd + 6'd1;
    end
  end

  assign working         = v;
  assign stat.last_round = ctrl.run && (rnd == 6'd63);

endmodule

`default_nettype wire

@@ sv/sha256_message_hasher.sv @@
// Top level of the SHA-256 message hasher: byte packing, padding, sequencer, digest output.
`default_nettype none

// SHA-256 over a byte stream. Send the message one byte per request on the
// s_axis side (tuser high marks a real byte); the request with tlast closes
// the message, with or without a byte of its own. Bytes are packed big-endian
// into words and shifted into a 16-word schedule window; byte requests are
// taken while the block is idle, but the one that fills a 64-byte block makes
// it busy for 64 rounds in the shared round unit at one round per cycle, then
// for the fold of the working words into the hash. On a closing request the
// block inserts the padding itself, one byte per cycle through the same packer
// (0x80, zeros up to byte 56, then the 64-bit bit count), which takes one
// compression, or two when the padding spills into a second block. The eight
// digest words then leave on the m_axis side, word 0 (most significant) first,
// tlast on word 7; after the last word the hash state and bit count return to
// their initial values. No new request is taken from the closing request until
// the last digest word has been taken.
module sha256_message_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] has_byte
  input  wire         s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_ROUNDS = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]  state, state_next;
  sha256_pkg::hash_t hash;
  logic [63:0] bit_length;
  logic [5:0]  pos;          // byte position within the block
  logic [23:0] acc;          // bytes of the word being packed
  logic        finishing;    // closing request in progress
  logic        mark_done;    // 0x80 byte already inserted
  logic        len_phase;    // length bytes being inserted
  logic [2:0]  out_idx;

  sha256_pkg::core_ctrl_t ctrl;
  sha256_pkg::core_stat_t stat;
  sha256_pkg::hash_t      working;

  logic       s_accept, m_accept;
  logic       ins_valid, len_now, word_done, block_done;
  logic [7:0] ins_byte;
  logic [63:0] len_shifted;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  // Pick the byte to pack: a message byte when idle, a padding byte otherwise.
  always_comb begin
    len_now     = mark_done && (len_phase || pos == 6'd56);
    len_shifted = bit_length >> {~pos[2:0], 3'b000};
    ins_valid   = (s_accept && s_axis_tuser) || (state == ST_PAD);
    if (state == ST_PAD) begin
      if (!mark_done) begin
        ins_byte = 8'h80;
      end else if (len_now) begin
        ins_byte = len_shifted[7:0];
      end else begin
        ins_byte = 8'h00;
      end
    end else begin
      ins_byte = s_axis_tdata;
    end
    word_done  = ins_valid && (pos[1:0] == 2'b11);
    block_done = ins_valid && (pos == 6'd63);
  end

  always_comb begin
    ctrl.push      = word_done;
    ctrl.push_word = {acc, ins_byte};
    ctrl.start     = block_done;
    ctrl.run       = (state == ST_ROUNDS);
  end

  sha256_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .hash_in (hash),
    .working (working),
    .stat    (stat)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (block_done) begin
            state_next = ST_ROUNDS;
          end else if (s_axis_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_done) begin
          state_next = ST_ROUNDS;
        end
      end
      ST_ROUNDS: begin
        if (stat.last_round) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_phase) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_accept && out_idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Byte packer: hold partial bytes until the word completes.
  always_ff @(posedge clk) begin
    if (ins_valid && !word_done) begin
      acc <= {acc[15:0], ins_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      bit_length <= '0;
      finishing  <= 1'b0;
      mark_done  <= 1'b0;
      len_phase  <= 1'b0;
      out_idx    <= '0;
      hash       <= sha256_pkg::INIT_H;
    end else begin
      if (ins_valid) begin
        pos <= pos + 6'd1;
      end
      if (s_accept && s_axis_tuser) begin
        bit_length <= bit_length + 64'd8;
      end
      if (s_accept && s_axis_tlast) begin
        finishing <= 1'b1;
      end
      if (state == ST_PAD) begin
        mark_done <= 1'b1;
        len_phase <= len_now;
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + working[i];
        end
      end
      if (m_accept) begin
        out_idx <= out_idx + 3'd1;
        // Drop back to a fresh message after the last digest word.
        if (out_idx == 3'd7) begin
          hash       <= sha256_pkg::INIT_H;
          bit_length <= '0;
          finishing  <= 1'b0;
          mark_done  <= 1'b0;
          len_phase  <= 1'b0;
        end
      end
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = hash[out_idx];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == 3'd7);

  // The round unit is never fed a word and a round in the same cycle.
  a_push_run_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.run))
    else $error("schedule push during a round");

  // The last round is always followed by the hash update.
  a_rounds_to_add: assert property (@(posedge clk) disable iff (rst)
    stat.last_round |=> state == ST_ADD)
    else $error("no hash update after round 63");

  // The digest goes out only on a block boundary with the length inserted.
  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> (pos == 6'd0) && len_phase && finishing)
    else $error("digest output before padding completed");

  // Input and output sides are never open together.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while digest pending");

  // After the final digest word the bit count starts over.
  a_len_cleared: assert property (@(posedge clk) disable iff (rst)
    (m_accept && out_idx == 3'd7) |=> bit_length == 64'd0 && state == ST_IDLE)
    else $error("state not cleared after digest");

endmodule

`default_nettype wire
